// ===== rtl/core/tisl_pkg.sv =====
// shared types and constants for the sensor table linearizer
`default_nettype none
package tisl_pkg;

  localparam int OUT_W        = 24;
  localparam int FRAC_BITS    = 8;
  localparam int OUT_MAX      = 8388607;
  localparam int POINTS_RESET = 13;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FETCH0,
    ST_FETCH1,
    ST_FETCH2,
    ST_FETCH3,
    ST_FETCH4,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } tisl_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/tisl_in_if.sv =====
// request channel: calibration point loads and sample converts
`default_nettype none
interface tisl_in_if #(
  parameter int IDX_W = 4,
  parameter int RB    = 12,
  parameter int DB    = 8
);
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [IDX_W-1:0] point_index;
  logic [RB-1:0] point_reading;
  logic [DB-1:0] point_distance;
  logic [RB-1:0] sample_reading;

  modport source (
    output valid, req_type, point_index, point_reading, point_distance, sample_reading,
    input  ready
  );
  modport sink (
    input  valid, req_type, point_index, point_reading, point_distance, sample_reading,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/tisl_out_if.sv =====
// result channel: interpolated distance and flags
`default_nettype none
interface tisl_out_if;
  import tisl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] distance_q8;
  logic                    extrapolated;
  logic                    saturated;

  modport source (
    output valid, distance_q8, extrapolated, saturated,
    input  ready
  );
  modport sink (
    input  valid, distance_q8, extrapolated, saturated,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/tisl_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module tisl_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/tisl_div.sv =====
// unsigned restoring divider, two quotient bits per cycle
`default_nettype none
module tisl_div #(
  parameter int DIV_W = 32,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);
  localparam int STEPS = DIV_W / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dsor_r, dsor_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    logic [DEN_W:0] r1;
    logic [DEN_W:0] r2;
    logic           b1;
    logic           b2;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    r1 = {rem_r, quo_r[DIV_W-1]};
    b1 = 1'b0;
    if (r1 >= {1'b0, dsor_r}) begin
      r1 = r1 - {1'b0, dsor_r};
      b1 = 1'b1;
    end
    r2 = {r1[DEN_W-1:0], quo_r[DIV_W-2]};
    b2 = 1'b0;
    if (r2 >= {1'b0, dsor_r}) begin
      r2 = r2 - {1'b0, dsor_r};
      b2 = 1'b1;
    end
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsor_nxt = divisor;
      cnt_nxt  = CW'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-3:0], b1, b2};
      rem_nxt = r2[DEN_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

// ===== rtl/core/table_interp_sensor_linearizer.sv =====
// top level: calibration table linearizer with search sequencer and output register
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      req_type, point_index, point_reading, point_distance,
//                                 sample_reading
//  out_ch   out  valid/ready      distance_q8, extrapolated, saturated
//  cfg_     in   cfg_wr_en        cfg_wr_data (points in use)
//
// a load is written to the table ram as it is accepted; a convert runs a binary search whose steps
// each read and compare on the table ram read port, then the fetch, multiply, sum and divide
// states and the two-bit-per-cycle divider before the result beat; the next request is taken
// once the sequencer is back in idle
// reset is synchronous and clears control state only; table contents are kept
// a finished result waits in the output register while the next request is taken;
// a second result stalls the sequencer until the first beat leaves
`default_nettype none
module table_interp_sensor_linearizer #(
  parameter int TABLE_DEPTH   = 16,
  parameter int READING_BITS  = 12,
  parameter int DISTANCE_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  tisl_in_if.sink                                  in_ch,
  tisl_out_if.source                               out_ch,
  input  wire logic                                cfg_wr_en,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]    cfg_wr_data
);
  import tisl_pkg::*;

  localparam int RB    = READING_BITS;
  localparam int DB    = DISTANCE_BITS;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PW    = DB + RB + 2;
  localparam int SW    = PW + 1;
  localparam int NUM_W = SW + FRAC_BITS;
  localparam int DIV_W = NUM_W + (NUM_W % 2);

  tisl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  points_r;
  logic [CNT_W-1:0]  n_act;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [RB-1:0]     x_r, x_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  mid_r, mid_nxt;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  il;
  logic [CNT_W-1:0]  ir;
  logic [RB-1:0]     r0_r, r0_nxt;
  logic [RB-1:0]     rn_r, rn_nxt;
  logic [RB-1:0]     xl_r, xl_nxt;
  logic [RB-1:0]     xr_r, xr_nxt;
  logic [DB-1:0]     yl_r, yl_nxt;
  logic [DB-1:0]     yr_r, yr_nxt;
  logic signed [PW-1:0] p1_r, p1_nxt;
  logic signed [PW-1:0] p2_r, p2_nxt;
  logic signed [RB:0]   den_r, den_nxt;
  logic                 extra_r, extra_nxt;
  logic                 neg_r, neg_nxt;

  logic signed [RB:0]   den_c;
  logic signed [RB:0]   dx_c;
  logic signed [DB:0]   dy_c;
  logic signed [DB:0]   yls_c;
  logic signed [SW-1:0] sum_c;
  logic signed [NUM_W-1:0] num_c;
  logic [NUM_W-1:0]     mag_c;
  logic [RB-1:0]        dmag_c;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [RB+DB-1:0]     ram_rdata;
  logic [RB-1:0]        rd_reading;
  logic [DB-1:0]        rd_distance;

  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [RB-1:0]        div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_dist_r, out_dist_nxt;
  logic                    out_extra_r, out_extra_nxt;
  logic                    out_sat_r, out_sat_nxt;

  logic                    sat_c;
  logic signed [OUT_W-1:0] dist_c;

  // points in use, clamped to the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= CNT_W'(POINTS_RESET);
    end else if (cfg_wr_en) begin
      points_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (points_r < CNT_W'(2)) begin
      n_act = CNT_W'(2);
    end else if (points_r > CNT_W'(TABLE_DEPTH)) begin
      n_act = CNT_W'(TABLE_DEPTH);
    end else begin
      n_act = points_r;
    end
  end

  assign ram_we = in_ch.valid && in_ch.ready && (in_ch.req_type == REQ_LOAD) &&
                  ({1'b0, in_ch.point_index} < (IDX_W + 1)'(TABLE_DEPTH));

  tisl_ram #(
    .WIDTH(RB + DB),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_ch.point_index),
    .wdata({in_ch.point_reading, in_ch.point_distance}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_reading  = ram_rdata[RB+DB-1:DB];
  assign rd_distance = ram_rdata[DB-1:0];

  tisl_div #(
    .DIV_W(DIV_W),
    .DEN_W(RB)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quo)
  );

  // segment selection from the search result
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign pos = (lo_r == '0) ? '0 : lo_r - CNT_W'(1);

  always_comb begin
    if (pos == '0) begin
      il = '0;
      ir = CNT_W'(1);
    end else if (pos >= n_r - CNT_W'(1)) begin
      il = n_r - CNT_W'(2);
      ir = n_r - CNT_W'(1);
    end else begin
      il = pos;
      ir = pos + CNT_W'(1);
    end
  end

  // interpolation arithmetic
  assign den_c = $signed({1'b0, xr_r}) - $signed({1'b0, xl_r});
  assign dx_c  = $signed({1'b0, x_r}) - $signed({1'b0, xl_r});
  assign dy_c  = $signed({1'b0, yr_r}) - $signed({1'b0, yl_r});
  assign yls_c = $signed({1'b0, yl_r});
  assign sum_c = SW'(p1_r) + SW'(p2_r);

  always_comb begin
    num_c = NUM_W'(sum_c) <<< FRAC_BITS;
    if (den_r < 0) begin
      num_c = -num_c;
    end
    mag_c  = (num_c < 0) ? NUM_W'(-num_c) : NUM_W'(num_c);
    dmag_c = (den_r < 0) ? RB'(-den_r) : RB'(den_r);
  end

  // saturation of the quotient magnitude
  always_comb begin
    sat_c  = 1'b0;
    dist_c = neg_r ? -$signed(div_quo[OUT_W-1:0]) : $signed(div_quo[OUT_W-1:0]);
    if (!neg_r && (div_quo > DIV_W'(OUT_MAX))) begin
      sat_c  = 1'b1;
      dist_c = OUT_W'(OUT_MAX);
    end else if (neg_r && (div_quo > DIV_W'(OUT_MAX) + DIV_W'(1))) begin
      sat_c  = 1'b1;
      dist_c = {1'b1, {(OUT_W-1){1'b0}}};
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    x_nxt         = x_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    r0_nxt        = r0_r;
    rn_nxt        = rn_r;
    xl_nxt        = xl_r;
    xr_nxt        = xr_r;
    yl_nxt        = yl_r;
    yr_nxt        = yr_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    den_nxt       = den_r;
    extra_nxt     = extra_r;
    neg_nxt       = neg_r;
    ram_raddr     = '0;
    div_start     = 1'b0;
    div_dividend  = DIV_W'(mag_c);
    div_divisor   = dmag_c;
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;
    out_extra_nxt = out_extra_r;
    out_sat_nxt   = out_sat_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.req_type == REQ_CONVERT) begin
          n_nxt     = n_act;
          x_nxt     = in_ch.sample_reading;
          lo_nxt    = '0;
          hi_nxt    = n_act;
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (lo_r < hi_r) begin
          ram_raddr = mid[IDX_W-1:0];
          mid_nxt   = mid;
          state_nxt = ST_SRCH_CMP;
        end else begin
          state_nxt = ST_FETCH0;
        end
      end
      ST_SRCH_CMP: begin
        if (rd_reading <= x_r) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SRCH_RD;
      end
      ST_FETCH0: begin
        ram_raddr = '0;
        state_nxt = ST_FETCH1;
      end
      ST_FETCH1: begin
        r0_nxt    = rd_reading;
        ram_raddr = IDX_W'(n_r - CNT_W'(1));
        state_nxt = ST_FETCH2;
      end
      ST_FETCH2: begin
        rn_nxt    = rd_reading;
        ram_raddr = il[IDX_W-1:0];
        state_nxt = ST_FETCH3;
      end
      ST_FETCH3: begin
        xl_nxt    = rd_reading;
        yl_nxt    = rd_distance;
        ram_raddr = ir[IDX_W-1:0];
        state_nxt = ST_FETCH4;
      end
      ST_FETCH4: begin
        xr_nxt    = rd_reading;
        yr_nxt    = rd_distance;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        p1_nxt    = yls_c * den_c;
        p2_nxt    = dy_c * dx_c;
        den_nxt   = den_c;
        extra_nxt = (x_r < r0_r) || (x_r > rn_r);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        div_start = 1'b1;
        if (den_r == '0) begin
          // flat segment: left distance, divided by one
          div_dividend = DIV_W'({yl_r, {FRAC_BITS{1'b0}}});
          div_divisor  = RB'(1);
          neg_nxt      = 1'b0;
        end else begin
          neg_nxt = (num_c < 0);
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_c;
          out_extra_nxt = extra_r;
          out_sat_nxt   = sat_c;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    x_r         <= x_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    r0_r        <= r0_nxt;
    rn_r        <= rn_nxt;
    xl_r        <= xl_nxt;
    xr_r        <= xr_nxt;
    yl_r        <= yl_nxt;
    yr_r        <= yr_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    den_r       <= den_nxt;
    extra_r     <= extra_nxt;
    neg_r       <= neg_nxt;
    out_dist_r  <= out_dist_nxt;
    out_extra_r <= out_extra_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.distance_q8  = out_dist_r;
  assign out_ch.extrapolated = out_extra_r;
  assign out_ch.saturated    = out_sat_r;
endmodule
`default_nettype wire

// ===== sim/table_interp_sensor_linearizer_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the calibration table linearizer: directed and random traffic
module table_interp_sensor_linearizer_test;
  import tisl_pkg::*;

  localparam int DEPTH         = 16;
  localparam int RD_W          = 12;
  localparam int DS_W          = 8;
  localparam int PTS_W         = 5;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic signed [OUT_W-1:0] distance_q8;
    logic                    extrapolated;
    logic                    saturated;
  } lin_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en;
  logic [PTS_W-1:0] cfg_wr_data;

  tisl_in_if #(.IDX_W(4), .RB(RD_W), .DB(DS_W)) in_if ();
  tisl_out_if out_if ();

  table_interp_sensor_linearizer #(
    .TABLE_DEPTH  (DEPTH),
    .READING_BITS (RD_W),
    .DISTANCE_BITS(DS_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if.sink),
    .out_ch     (out_if.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [RD_W-1:0]  cal_reading  [DEPTH];
  logic [DS_W-1:0]  cal_distance [DEPTH];
  logic [PTS_W-1:0] points_cfg;
  lin_result_t      pending_results [$];
  int               err_count = 0;
  int               cycle_count = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("table_interp_sensor_linearizer_test: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic int unsigned active_points();
    int unsigned n;
    n = points_cfg;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic lin_result_t interpolate_distance(input logic [RD_W-1:0] x);
    int unsigned n, lo, hi, mid, pos, il, ir;
    longint      xl, xr, yl, yr, den, num, q;
    lin_result_t r;
    n  = active_points();
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (cal_reading[mid] <= x) lo = mid + 1;
      else hi = mid;
    end
    pos = (lo == 0) ? 0 : lo - 1;
    if (pos == 0) begin
      il = 0;
      ir = 1;
    end else if (pos >= n - 1) begin
      il = n - 2;
      ir = n - 1;
    end else begin
      il = pos;
      ir = pos + 1;
    end
    xl = longint'(cal_reading[il]);
    xr = longint'(cal_reading[ir]);
    yl = longint'(cal_distance[il]);
    yr = longint'(cal_distance[ir]);
    r.extrapolated = (x < cal_reading[0]) || (x > cal_reading[n-1]);
    r.saturated = 1'b0;
    den = xr - xl;
    if (den == 0) begin
      q = yl * 256;
    end else begin
      num = yl * 256 * den + (yr - yl) * (longint'(x) - xl) * 256;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      q = num / den;
    end
    if (q > 64'sd8388607) begin
      q = 64'sd8388607;
      r.saturated = 1'b1;
    end
    if (q < -64'sd8388608) begin
      q = -64'sd8388608;
      r.saturated = 1'b1;
    end
    r.distance_q8 = q[OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [RD_W-1:0] pick_sample();
    int unsigned n, sel, k, lo, hi;
    int          v;
    n   = active_points();
    sel = $urandom_range(99);
    if (sel < 40) return RD_W'($urandom);
    if (sel < 70) begin
      k = $urandom_range(n - 1);
      v = int'(cal_reading[k]) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return RD_W'(v);
    end
    if (sel < 80) return sel[0] ? {RD_W{1'b1}} : {RD_W{1'b0}};
    lo = cal_reading[0];
    hi = cal_reading[n-1];
    if (hi > lo) return RD_W'(lo + $urandom_range(hi - lo));
    return RD_W'($urandom);
  endfunction

  task automatic send_request(input logic req, input logic [3:0] idx,
                              input logic [RD_W-1:0] rd, input logic [DS_W-1:0] pdist,
                              input logic [RD_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.req_type       <= req;
    in_if.point_index    <= idx;
    in_if.point_reading  <= rd;
    in_if.point_distance <= pdist;
    in_if.sample_reading <= smp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (req == REQ_LOAD) begin
      cal_reading[idx]  = rd;
      cal_distance[idx] = pdist;
    end else begin
      pending_results.push_back(interpolate_distance(smp));
    end
  endtask

  task automatic load_point(input logic [3:0] idx, input logic [RD_W-1:0] rd,
                            input logic [DS_W-1:0] pdist);
    send_request(REQ_LOAD, idx, rd, pdist, RD_W'($urandom));
  endtask

  task automatic convert_sample(input logic [RD_W-1:0] smp);
    send_request(REQ_CONVERT, 4'($urandom), RD_W'($urandom), DS_W'($urandom), smp);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_points(input logic [PTS_W-1:0] pts);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pts;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    points_cfg  = pts;
  endtask

  // result side: random backpressure and in-order compare
  initial begin
    lin_result_t exp_r;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_r = pending_results.pop_front();
          if (out_if.distance_q8 !== exp_r.distance_q8)
            report_mismatch($sformatf("distance_q8 got %0d want %0d",
                                      out_if.distance_q8, exp_r.distance_q8));
          if (out_if.extrapolated !== exp_r.extrapolated)
            report_mismatch($sformatf("extrapolated got %b want %b",
                                      out_if.extrapolated, exp_r.extrapolated));
          if (out_if.saturated !== exp_r.saturated)
            report_mismatch($sformatf("saturated got %b want %b",
                                      out_if.saturated, exp_r.saturated));
        end
      end
      out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_fill_table();
    for (int i = 0; i < DEPTH; i++)
      load_point(4'(i), (i == DEPTH - 1) ? RD_W'(4095) : RD_W'(200 + 250 * i),
                 (i == 0) ? DS_W'(0) : (i == DEPTH - 1) ? DS_W'(255) : DS_W'(i * 97));
  endtask

  // reset point count of 13, last in-use reading 3200
  task automatic test_span_edges();
    convert_sample(RD_W'(0));
    convert_sample(RD_W'(199));
    convert_sample(RD_W'(200));
    convert_sample(RD_W'(1325));
    convert_sample(RD_W'(3200));
    convert_sample(RD_W'(3201));
    convert_sample(RD_W'(4095));
  endtask

  task automatic test_points_clamp();
    set_points(PTS_W'(0));
    convert_sample(RD_W'(100));
    convert_sample(RD_W'(1000));
    set_points(PTS_W'(31));
    convert_sample(RD_W'(3000));
    convert_sample(RD_W'(4095));
    set_points(PTS_W'(1));
    convert_sample(RD_W'(450));
  endtask

  task automatic test_saturation();
    load_point(4'd0, RD_W'(1000), DS_W'(0));
    load_point(4'd1, RD_W'(1001), DS_W'(255));
    set_points(PTS_W'(2));
    convert_sample(RD_W'(4095));
    convert_sample(RD_W'(0));
    convert_sample(RD_W'(1000));
  endtask

  task automatic test_flat_and_reversed();
    load_point(4'd0, RD_W'(0), DS_W'(77));
    load_point(4'd1, RD_W'(0), DS_W'(200));
    convert_sample(RD_W'(0));
    convert_sample(RD_W'(4095));
    load_point(4'd0, RD_W'(3000), DS_W'(10));
    load_point(4'd1, RD_W'(1000), DS_W'(250));
    convert_sample(RD_W'(2000));
    convert_sample(RD_W'(500));
    convert_sample(RD_W'(3500));
  endtask

  // mostly ascending tables with random content, some flat steps and unordered ones
  task automatic run_random_phase(input int idle, input int stall,
                                  input logic [PTS_W-1:0] pts, input int count);
    int unsigned shape;
    int          rd;
    set_points(pts);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    shape = $urandom_range(99);
    rd    = $urandom_range(300);
    for (int i = 0; i < DEPTH; i++) begin
      if (shape >= 85) rd = $urandom_range(4095);
      else if (i > 0 && !(shape >= 70 && $urandom_range(2) == 0)) rd += $urandom_range(520);
      if (rd > 4095) rd = 4095;
      load_point(4'(i), RD_W'(rd), DS_W'($urandom));
    end
    for (int i = DEPTH; i < count; i++) begin
      if ($urandom_range(99) < 15) load_point(4'($urandom), RD_W'($urandom), DS_W'($urandom));
      else convert_sample(pick_sample());
    end
  endtask

  task automatic test_random_traffic();
    logic [PTS_W-1:0] pts_list [8];
    int               idle_list [4];
    int               stall_list [4];
    pts_list   = '{PTS_W'(2), PTS_W'(16), PTS_W'(0), PTS_W'(31),
                   PTS_W'(13), PTS_W'(1), PTS_W'(17), PTS_W'($urandom)};
    idle_list  = '{0, 85, 0, 19};
    stall_list = '{0, 0, 85, 19};
    for (int p = 0; p < 8; p++)
      run_random_phase(idle_list[p % 4], stall_list[p % 4], pts_list[p], 130);
  endtask

  initial begin
    in_if.valid          = 1'b0;
    in_if.req_type       = REQ_LOAD;
    in_if.point_index    = '0;
    in_if.point_reading  = '0;
    in_if.point_distance = '0;
    in_if.sample_reading = '0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    points_cfg           = PTS_W'(POINTS_RESET);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_table();
    test_span_edges();
    test_points_clamp();
    test_saturation();
    test_flat_and_reversed();
    test_random_traffic();
    wait_idle();
    if (err_count == 0 && pending_results.size() == 0)
      $display("table_interp_sensor_linearizer_test: clean");
    else
      $display("table_interp_sensor_linearizer_test: errors");
    $finish;
  end

endmodule
